// File: design/vpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_pkg
// Types and constants shared by the vertex projection, clip and viewport block.
// ----------------------------------------------------------------------------
package vpc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int PIX_WIDTH   = 13;
  localparam int CFG_WIDTH   = 64;
  localparam int FRAC_SHIFT  = 16;

  typedef enum logic [2:0] {
    CFG_COL_X    = 3'd0,
    CFG_COL_Y    = 3'd1,
    CFG_COL_Z    = 3'd2,
    CFG_COL_W    = 3'd3,
    CFG_SCREEN_W = 3'd4,
    CFG_SCREEN_H = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } vertex_t;

  typedef struct packed {
    logic                 visible;
    logic [PIX_WIDTH-1:0] screen_x;
    logic [PIX_WIDTH-1:0] screen_y;
  } result_t;

endpackage
`default_nettype wire

// File: design/vertex_project_clip_viewport.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_project_clip_viewport
// Transforms a vertex by a 4x4 matrix, clips it and maps it to a pixel.
// ----------------------------------------------------------------------------
// Usage: drive an item on vertex and raise start; it is taken at any rising
// edge where start is high and busy is low. busy is always low, so one item
// can be taken in every cycle. The result appears on result with done high
// for exactly one cycle, after the item has passed through five stages for
// the matrix products, the sums, the sign fix, the clip tests and the
// split viewport multiply, one stage that joins the partial products, then
// thirteen stages of a restoring divider that yields one quotient bit per
// stage and drives the outputs directly. Results leave in the order the
// items entered. The receiver cannot stall the block.
// Configuration writes use cfg_we, cfg_index and cfg_data and take effect at
// once; the user must make them only while no item is in flight, which the
// block does not enforce. Synchronous reset empties the pipeline and loads
// the identity matrix and a 640 by 480 viewport.
// ----------------------------------------------------------------------------
module vertex_project_clip_viewport #(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire vpc_pkg::vertex_t              vertex,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [vpc_pkg::CFG_WIDTH-1:0] cfg_data,
  output logic                               done,
  output vpc_pkg::result_t                   result
);

  localparam int KW   = COEF_WIDTH;
  localparam int CW   = vpc_pkg::COORD_WIDTH;
  localparam int PXW  = vpc_pkg::PIX_WIDTH;
  localparam int PW   = CW + KW;
  localparam int SW   = PW + 2;
  localparam int AW   = SW + 1;
  localparam int NXW  = AW + 1;
  localparam int LW   = NXW / 2;
  localparam int HW   = NXW - LW;
  localparam int NW   = NXW + PXW;
  localparam int EXTW = (4 * KW > vpc_pkg::CFG_WIDTH) ? 4 * KW : vpc_pkg::CFG_WIDTH;
  localparam int NDIV = PXW;
  localparam logic [vpc_pkg::CFG_WIDTH-1:0] ONE = vpc_pkg::CFG_WIDTH'(4096);

  logic [vpc_pkg::CFG_WIDTH-1:0] col [4];
  logic [PXW-1:0] scr_w;
  logic [PXW-1:0] scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      col[0] <= ONE;
      col[1] <= ONE << KW;
      col[2] <= ONE << (2 * KW);
      col[3] <= (3 * KW < vpc_pkg::CFG_WIDTH) ? (ONE << (3 * KW)) : '0;
      scr_w  <= PXW'(640);
      scr_h  <= PXW'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        vpc_pkg::CFG_COL_X:    col[0] <= cfg_data;
        vpc_pkg::CFG_COL_Y:    col[1] <= cfg_data;
        vpc_pkg::CFG_COL_Z:    col[2] <= cfg_data;
        vpc_pkg::CFG_COL_W:    col[3] <= cfg_data;
        vpc_pkg::CFG_SCREEN_W: scr_w  <= cfg_data[PXW-1:0];
        vpc_pkg::CFG_SCREEN_H: scr_h  <= cfg_data[PXW-1:0];
        default: ;
      endcase
    end
  end

  logic [EXTW-1:0] colx [4];
  logic signed [KW-1:0] coef [4][4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      colx[c] = EXTW'(col[c]);
      for (int i = 0; i < 4; i++) begin
        coef[c][i] = $signed(colx[c][i*KW +: KW]);
      end
    end
  end

  assign busy = 1'b0;

  // Stage 1: products.
  logic v1;
  logic signed [PW-1:0] prod [4][3];
  logic signed [KW-1:0] cterm [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    for (int c = 0; c < 4; c++) begin
      prod[c][0] <= vertex.pos_x * coef[c][0];
      prod[c][1] <= vertex.pos_y * coef[c][1];
      prod[c][2] <= vertex.pos_z * coef[c][2];
      cterm[c]   <= coef[c][3];
    end
  end

  // Stage 2: dot products.
  logic v2;
  logic signed [AW-1:0] clip [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int c = 0; c < 4; c++) begin
      clip[c] <= AW'(prod[c][0]) + AW'(prod[c][1]) + AW'(prod[c][2])
               + (AW'(cterm[c]) <<< vpc_pkg::FRAC_SHIFT);
    end
  end

  // Stage 3: make w positive.
  logic v3;
  logic wzero;
  logic signed [AW-1:0] hc [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    wzero <= (clip[3] == '0);
    for (int c = 0; c < 4; c++) begin
      hc[c] <= clip[3][AW-1] ? -clip[c] : clip[c];
    end
  end

  // Stage 4: clip tests and viewport numerators.
  logic v4;
  logic vis4;
  logic [NXW-1:0] nx;
  logic [NXW-1:0] ny;
  logic [NXW-1:0] dv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    vis4 <= !wzero && (hc[2] >= 0) && (hc[2] <= hc[3])
         && (hc[0] >= -hc[3]) && (hc[0] <= hc[3])
         && (hc[1] >= -hc[3]) && (hc[1] <= hc[3]);
    nx  <= NXW'(hc[0]) + NXW'(hc[3]);
    ny  <= NXW'(hc[3]) - NXW'(hc[1]);
    dv4 <= NXW'(hc[3]) << 1;
  end

  // Stage 5: split viewport multiply.
  logic v5;
  logic vis5;
  logic [NXW-1:0] dv5;
  logic [LW+PXW-1:0] plo_x;
  logic [LW+PXW-1:0] plo_y;
  logic [HW+PXW-1:0] phi_x;
  logic [HW+PXW-1:0] phi_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    vis5  <= vis4;
    dv5   <= dv4;
    plo_x <= nx[LW-1:0] * scr_w;
    plo_y <= ny[LW-1:0] * scr_h;
    phi_x <= nx[NXW-1:LW] * scr_w;
    phi_y <= ny[NXW-1:LW] * scr_h;
  end

  // Divider: one quotient bit per stage, most significant first.
  logic           dvalid [NDIV+1];
  logic           dvis   [NDIV+1];
  logic [NXW-1:0] dden   [NDIV+1];
  logic [NW-1:0]  rem_x  [NDIV+1];
  logic [NW-1:0]  rem_y  [NDIV+1];
  logic [PXW-1:0] q_x    [NDIV+1];
  logic [PXW-1:0] q_y    [NDIV+1];
  logic [NW-1:0]  dsh    [NDIV];
  logic           ge_x   [NDIV];
  logic           ge_y   [NDIV];

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      dsh[k]  = NW'(dden[k]) << (NDIV - 1 - k);
      ge_x[k] = rem_x[k] >= dsh[k];
      ge_y[k] = rem_y[k] >= dsh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NDIV; k++) begin
        dvalid[k] <= 1'b0;
      end
    end else begin
      dvalid[0] <= v5;
      for (int k = 0; k < NDIV; k++) begin
        dvalid[k+1] <= dvalid[k];
      end
    end
    dvis[0]  <= vis5;
    dden[0]  <= dv5;
    rem_x[0] <= (NW'(phi_x) << LW) + NW'(plo_x);
    rem_y[0] <= (NW'(phi_y) << LW) + NW'(plo_y);
    q_x[0]   <= '0;
    q_y[0]   <= '0;
    for (int k = 0; k < NDIV; k++) begin
      dvis[k+1]  <= dvis[k];
      dden[k+1]  <= dden[k];
      rem_x[k+1] <= ge_x[k] ? rem_x[k] - dsh[k] : rem_x[k];
      rem_y[k+1] <= ge_y[k] ? rem_y[k] - dsh[k] : rem_y[k];
      q_x[k+1]   <= {q_x[k][PXW-2:0], ge_x[k]};
      q_y[k+1]   <= {q_y[k][PXW-2:0], ge_y[k]};
    end
  end

  assign done            = dvalid[NDIV];
  assign result.visible  = dvis[NDIV];
  assign result.screen_x = dvis[NDIV] ? q_x[NDIV] : '0;
  assign result.screen_y = dvis[NDIV] ? q_y[NDIV] : '0;

endmodule
`default_nettype wire

// File: tb/vertex_project_clip_viewport_checker.sv
// ----------------------------------------------------------------------------
// vertex_project_clip_viewport_checker
// Watches the item and result channels and the configuration port, predicts
// each projected pixel from its own copy of the matrix and viewport, and
// compares every result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module vertex_project_clip_viewport_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire vpc_pkg::vertex_t              vertex,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [vpc_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                          done,
  input  wire vpc_pkg::result_t              result,
  output int                                 errors,
  output int                                 pending
);

  logic [63:0]      col_x, col_y, col_z, col_w;
  logic [12:0]      scr_w, scr_h;
  vpc_pkg::result_t pixel_q[$];

  function automatic logic signed [63:0] coef(logic [63:0] col, int i);
    logic signed [15:0] c;
    c = col[i*16 +: 16];
    return 64'(c);
  endfunction

  function automatic logic signed [63:0] clip_dot(logic [63:0] col, vpc_pkg::vertex_t v);
    return 64'(v.pos_x) * coef(col, 0) + 64'(v.pos_y) * coef(col, 1)
         + 64'(v.pos_z) * coef(col, 2) + coef(col, 3) * 64'sd65536;
  endfunction

  function automatic vpc_pkg::result_t project_vertex(vpc_pkg::vertex_t v);
    logic signed [63:0] cx, cy, cz, cw;
    logic [127:0] num;
    vpc_pkg::result_t r;
    r = '0;
    cx = clip_dot(col_x, v);
    cy = clip_dot(col_y, v);
    cz = clip_dot(col_z, v);
    cw = clip_dot(col_w, v);
    if (cw == 0) return r;
    if (cw < 0) begin
      cx = -cx; cy = -cy; cz = -cz; cw = -cw;
    end
    if (cz < 0 || cz > cw || cx < -cw || cx > cw || cy < -cw || cy > cw) return r;
    r.visible = 1'b1;
    num = 128'(cx + cw) * 128'(scr_w);
    r.screen_x = 13'(num / (128'(cw) * 2));
    num = 128'(cw - cy) * 128'(scr_h);
    r.screen_y = 13'(num / (128'(cw) * 2));
    return r;
  endfunction

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    if (rst) begin
      col_x <= 64'd4096;
      col_y <= 64'd4096 << 16;
      col_z <= 64'd4096 << 32;
      col_w <= 64'd4096 << 48;
      scr_w <= 13'd640;
      scr_h <= 13'd480;
      pixel_q.delete();
      errors <= 0;
    end else begin
      if (done) begin
        if (pixel_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", result);
          errors <= errors + 1;
        end else begin
          if (pixel_q[0] !== result) begin
            if (errors < 10) $display("mismatch: expected %p actual %p", pixel_q[0], result);
            errors <= errors + 1;
          end
          void'(pixel_q.pop_front());
        end
      end
      if (start && !busy) pixel_q.push_back(project_vertex(vertex));
      if (cfg_we) begin
        case (cfg_index)
          vpc_pkg::CFG_COL_X:    col_x <= cfg_data;
          vpc_pkg::CFG_COL_Y:    col_y <= cfg_data;
          vpc_pkg::CFG_COL_Z:    col_z <= cfg_data;
          vpc_pkg::CFG_COL_W:    col_w <= cfg_data;
          vpc_pkg::CFG_SCREEN_W: scr_w <= cfg_data[12:0];
          vpc_pkg::CFG_SCREEN_H: scr_h <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/vertex_project_clip_viewport_tb.sv
// ----------------------------------------------------------------------------
// vertex_project_clip_viewport_tb
// Drives directed and random vertices in bursts through several matrix and
// viewport settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module vertex_project_clip_viewport_tb;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  vpc_pkg::vertex_t vertex = '0;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = 3'd0;
  logic [63:0]      cfg_data = '0;
  logic             done;
  vpc_pkg::result_t result;
  int               errors, pending;
  int               cycles = 0;

  localparam int LIMIT = 400000;

  vertex_project_clip_viewport dut (.*);
  vertex_project_clip_viewport_checker chk (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("vertex_project_clip_viewport_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(vpc_pkg::cfg_index_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic send_vertex(vpc_pkg::vertex_t v);
    start <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return 32'($signed($urandom_range(0, 16384)) - 8192);
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
    endcase
  endfunction

  task automatic random_items(int n);
    int left;
    left = n;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) burst = 40;
      for (int i = 0; i < burst && left > 0; i++) begin
        send_vertex('{rand_coord(), rand_coord(), rand_coord()});
        left--;
      end
      idle_gap();
    end
  endtask

  function automatic logic [63:0] rand_col(int lane_one);
    logic [63:0] c;
    c = '0;
    for (int i = 0; i < 4; i++)
      c[i*16 +: 16] = (i == lane_one) ? 16'($urandom_range(2048, 6144))
                                      : 16'($signed($urandom_range(0, 2048)) - 1024);
    if ($urandom_range(0, 4) == 0) c = {$urandom, $urandom};
    return c;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_vertex('{32'sd0, 32'sd0, 32'sd0});
    send_vertex('{32'sh10000, 32'shFFFF0000, 32'sh10000});
    send_vertex('{32'shFFFF0000, 32'sh10000, 32'sd0});
    send_vertex('{32'sh10001, 32'sd0, 32'sh8000});
    send_vertex('{32'sd0, 32'sh8000, 32'shFFFFFFFF});
    send_vertex('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
    send_vertex('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
    send_vertex('{32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh10000});
    idle_gap();
    drain();
    // Zero W: last column all zero; then negative W.
    write_reg(vpc_pkg::CFG_COL_W, 64'd0);
    send_vertex('{32'sh4000, 32'sh4000, 32'sh4000});
    idle_gap();
    drain();
    write_reg(vpc_pkg::CFG_COL_W, {16'hF000, 48'd0});
    write_reg(vpc_pkg::CFG_COL_X, {48'd0, 16'hF000});
    write_reg(vpc_pkg::CFG_COL_Y, {32'd0, 16'hF000, 16'd0});
    write_reg(vpc_pkg::CFG_COL_Z, {16'd0, 16'hF000, 32'd0});
    send_vertex('{32'sh8000, 32'shFFFF8000, 32'sh8000});
    send_vertex('{32'sh10000, 32'shFFFF0000, 32'sh10000});
    send_vertex('{32'sh8000, 32'sh8000, 32'sh20000});
    idle_gap();
    drain();
    write_reg(vpc_pkg::CFG_SCREEN_W, 64'd0);
    write_reg(vpc_pkg::CFG_SCREEN_H, 64'd8191);
    send_vertex('{32'shFFFF8000, 32'sh8000, 32'shFFFF8000});
    send_vertex('{32'shFFFF0000, 32'sh10000, 32'shFFFF0000});
    idle_gap();
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(vpc_pkg::CFG_COL_X, rand_col(0));
      write_reg(vpc_pkg::CFG_COL_Y, rand_col(1));
      write_reg(vpc_pkg::CFG_COL_Z, rand_col(2));
      write_reg(vpc_pkg::CFG_COL_W, rand_col(3));
      case (phase)
        0: begin
          write_reg(vpc_pkg::CFG_SCREEN_W, 64'd1);
          write_reg(vpc_pkg::CFG_SCREEN_H, 64'd4096);
        end
        1: begin
          write_reg(vpc_pkg::CFG_SCREEN_W, 64'd4096);
          write_reg(vpc_pkg::CFG_SCREEN_H, 64'd1);
        end
        2: begin
          write_reg(vpc_pkg::CFG_SCREEN_W, 64'd8191);
          write_reg(vpc_pkg::CFG_SCREEN_H, 64'd0);
        end
        3: begin
          write_reg(vpc_pkg::CFG_SCREEN_W, '1);
          write_reg(vpc_pkg::CFG_SCREEN_H, '1);
        end
        default: begin
          write_reg(vpc_pkg::CFG_SCREEN_W, 64'($urandom));
          write_reg(vpc_pkg::CFG_SCREEN_H, 64'($urandom_range(1, 4096)));
        end
      endcase
      random_items(62);
      drain();
    end
    start <= 1'b0;
    drain();
    if (errors == 0)
      $display("vertex_project_clip_viewport_tb OK");
    else
      $display("vertex_project_clip_viewport_tb NOT OK");
    $finish;
  end
endmodule
